// ===== rtl/core/owbm_pkg.sv =====
package owbm_pkg;

  // timer width for all timed phases
  localparam int TIMER_BITS = 10;
  localparam int TIMER_MAX  = (2 ** TIMER_BITS) - 1;

  // configuration register file
  localparam int CFG_W      = 10;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_CFG);
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  // fixed released gap after each write slot
  localparam int GAP_US = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_REC   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SHORT = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_LONG  = CFG_IDX_W'(7);

  // register reset values
  localparam logic [CFG_W-1:0] RST_RESET_LOW   = CFG_W'(485);
  localparam logic [CFG_W-1:0] RST_PRES_WAIT   = CFG_W'(50);
  localparam logic [CFG_W-1:0] RST_RESET_REC   = CFG_W'(500);
  localparam logic [CFG_W-1:0] RST_READ_LOW    = CFG_W'(2);
  localparam logic [CFG_W-1:0] RST_READ_SAMPLE = CFG_W'(13);
  localparam logic [CFG_W-1:0] RST_READ_TAIL   = CFG_W'(45);
  localparam logic [CFG_W-1:0] RST_WRITE_SHORT = CFG_W'(3);
  localparam logic [CFG_W-1:0] RST_WRITE_LONG  = CFG_W'(65);

  // request codes
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RESET = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  // timing settings handed to the sequencer
  typedef struct packed {
    logic [CFG_W-1:0] reset_low_us;
    logic [CFG_W-1:0] presence_wait_us;
    logic [CFG_W-1:0] reset_recovery_us;
    logic [CFG_W-1:0] read_low_us;
    logic [CFG_W-1:0] read_sample_us;
    logic [CFG_W-1:0] read_tail_us;
    logic [CFG_W-1:0] write_short_us;
    logic [CFG_W-1:0] write_long_us;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       op_done;
    logic [7:0] read_data;
    logic       no_presence;
  } res_t;

  localparam int LOAD_W = (CFG_W > TIMER_BITS) ? CFG_W : TIMER_BITS;

  // zero acts as one microsecond, long values saturate at the timer limit
  function automatic logic [TIMER_BITS-1:0] load_time(input logic [CFG_W-1:0] us);
    logic [LOAD_W-1:0] u;
    logic [LOAD_W-1:0] lim;
    u   = LOAD_W'(us);
    lim = LOAD_W'(TIMER_MAX);
    if (u == '0) begin
      u = LOAD_W'(1);
    end else if (u > lim) begin
      u = lim;
    end
    return TIMER_BITS'(u);
  endfunction

endpackage

// ===== rtl/core/owbm_if.sv =====
// request channel: one tick or command item
interface owbm_req_if
  import owbm_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       bus_level;

  modport source (output valid, output req_type, output data_byte, output bus_level,
                  input ready);
  modport sink   (input valid, input req_type, input data_byte, input bus_level,
                  output ready);
endinterface

// result channel: one status item per request
interface owbm_res_if
  import owbm_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       op_done;
  logic [7:0] read_data;
  logic       no_presence;

  modport source (output valid, output drive_low, output busy_res, output op_done,
                  output read_data, output no_presence, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input op_done,
                  input read_data, input no_presence, output ready);
endinterface

// ===== rtl/core/owbm_cfg_regs.sv =====
module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;
  logic [CFG_W-1:0]     wval;
  logic [CFG_W-1:0]     rval;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wval   = pwdata[CFG_W-1:0];
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us      <= RST_RESET_LOW;
      cfg.presence_wait_us  <= RST_PRES_WAIT;
      cfg.reset_recovery_us <= RST_RESET_REC;
      cfg.read_low_us       <= RST_READ_LOW;
      cfg.read_sample_us    <= RST_READ_SAMPLE;
      cfg.read_tail_us      <= RST_READ_TAIL;
      cfg.write_short_us    <= RST_WRITE_SHORT;
      cfg.write_long_us     <= RST_WRITE_LONG;
    end else if (wr_en) begin
      unique case (idx)
        CFG_RESET_LOW:   cfg.reset_low_us      <= wval;
        CFG_PRES_WAIT:   cfg.presence_wait_us  <= wval;
        CFG_RESET_REC:   cfg.reset_recovery_us <= wval;
        CFG_READ_LOW:    cfg.read_low_us       <= wval;
        CFG_READ_SAMPLE: cfg.read_sample_us    <= wval;
        CFG_READ_TAIL:   cfg.read_tail_us      <= wval;
        CFG_WRITE_SHORT: cfg.write_short_us    <= wval;
        CFG_WRITE_LONG:  cfg.write_long_us     <= wval;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      CFG_RESET_LOW:   rval = cfg.reset_low_us;
      CFG_PRES_WAIT:   rval = cfg.presence_wait_us;
      CFG_RESET_REC:   rval = cfg.reset_recovery_us;
      CFG_READ_LOW:    rval = cfg.read_low_us;
      CFG_READ_SAMPLE: rval = cfg.read_sample_us;
      CFG_READ_TAIL:   rval = cfg.read_tail_us;
      CFG_WRITE_SHORT: rval = cfg.write_short_us;
      CFG_WRITE_LONG:  rval = cfg.write_long_us;
      default:         rval = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rval);

endmodule

// ===== rtl/core/owbm_seq.sv =====
module owbm_seq
  import owbm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [1:0] req_type,
  input  logic [7:0] data_byte,
  input  logic       bus_level,
  input  cfg_t       cfg,
  output res_t       res_next
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_RD_LOW,
    PH_RD_WAIT,
    PH_RD_TAIL,
    PH_WR_FIRST,
    PH_WR_SECOND,
    PH_WR_GAP
  } phase_t;

  phase_t                phase, phase_next;
  logic [1:0]            op_kind, op_kind_next;
  logic [TIMER_BITS-1:0] time_left, time_left_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [7:0]            received_byte, received_byte_next;
  logic                  absent_flag, absent_flag_next;
  logic                  drive_reg, drive_reg_next;
  logic                  done;
  logic                  cur_bit;
  logic                  nxt_bit;
  logic [2:0]            bit_inc;

  assign cur_bit = shift_byte[bit_index];
  assign bit_inc = bit_index + 3'd1;
  assign nxt_bit = shift_byte[bit_inc];

  // next state for one item
  always_comb begin
    phase_next         = phase;
    op_kind_next       = op_kind;
    time_left_next     = time_left;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    received_byte_next = received_byte;
    absent_flag_next   = absent_flag;
    drive_reg_next     = drive_reg;
    done               = 1'b0;

    if (phase == PH_IDLE) begin
      // start a command
      if (req_type == REQ_RESET) begin
        op_kind_next   = REQ_RESET;
        phase_next     = PH_RST_LOW;
        time_left_next = load_time(cfg.reset_low_us);
        drive_reg_next = 1'b1;
      end else if (req_type == REQ_WRITE) begin
        op_kind_next    = REQ_WRITE;
        shift_byte_next = data_byte;
        bit_index_next  = 3'd0;
        phase_next      = PH_WR_FIRST;
        time_left_next  = load_time(data_byte[0] ? cfg.write_short_us : cfg.write_long_us);
        drive_reg_next  = 1'b1;
      end else if (req_type == REQ_READ) begin
        op_kind_next    = REQ_READ;
        shift_byte_next = 8'd0;
        bit_index_next  = 3'd0;
        phase_next      = PH_RD_LOW;
        time_left_next  = load_time(cfg.read_low_us);
        drive_reg_next  = 1'b1;
      end
    end else if (req_type == REQ_TICK) begin
      if (time_left > TIMER_BITS'(1)) begin
        time_left_next = time_left - TIMER_BITS'(1);
      end else begin
        // timer ran out: move to the next phase on this tick
        unique case (phase)
          PH_RST_LOW: begin
            phase_next     = PH_RST_WAIT;
            time_left_next = load_time(cfg.presence_wait_us);
            drive_reg_next = 1'b0;
          end
          PH_RST_WAIT: begin
            absent_flag_next = bus_level;
            phase_next       = PH_RST_REC;
            time_left_next   = load_time(cfg.reset_recovery_us);
            drive_reg_next   = 1'b0;
          end
          PH_RD_LOW: begin
            phase_next     = PH_RD_WAIT;
            time_left_next = load_time(cfg.read_sample_us);
            drive_reg_next = 1'b0;
          end
          PH_RD_WAIT: begin
            shift_byte_next[bit_index] = bus_level;
            phase_next     = PH_RD_TAIL;
            time_left_next = load_time(cfg.read_tail_us);
            drive_reg_next = 1'b0;
          end
          PH_RD_TAIL: begin
            if (bit_index == 3'd7) begin
              received_byte_next = shift_byte;
              phase_next         = PH_IDLE;
              time_left_next     = '0;
              drive_reg_next     = 1'b0;
              done               = 1'b1;
            end else begin
              bit_index_next = bit_inc;
              phase_next     = PH_RD_LOW;
              time_left_next = load_time(cfg.read_low_us);
              drive_reg_next = 1'b1;
            end
          end
          PH_WR_FIRST: begin
            phase_next     = PH_WR_SECOND;
            time_left_next = load_time(cur_bit ? cfg.write_long_us : cfg.write_short_us);
            drive_reg_next = 1'b0;
          end
          PH_WR_SECOND: begin
            phase_next     = PH_WR_GAP;
            time_left_next = load_time(CFG_W'(GAP_US));
            drive_reg_next = 1'b0;
          end
          PH_WR_GAP: begin
            if (bit_index == 3'd7) begin
              phase_next     = PH_IDLE;
              time_left_next = '0;
              drive_reg_next = 1'b0;
              done           = 1'b1;
            end else begin
              bit_index_next = bit_inc;
              phase_next     = PH_WR_FIRST;
              time_left_next = load_time(nxt_bit ? cfg.write_short_us
                                                 : cfg.write_long_us);
              drive_reg_next = 1'b1;
            end
          end
          // reset recovery end
          PH_RST_REC: begin
            phase_next     = PH_IDLE;
            time_left_next = '0;
            drive_reg_next = 1'b0;
            done           = 1'b1;
          end
          default: begin
            phase_next     = PH_IDLE;
            time_left_next = '0;
            drive_reg_next = 1'b0;
          end
        endcase
      end
    end
  end

  // result seen after this item
  assign res_next.drive_low   = drive_reg_next;
  assign res_next.busy_res    = (phase_next != PH_IDLE);
  assign res_next.op_done     = done;
  assign res_next.read_data   = received_byte_next;
  assign res_next.no_presence = absent_flag_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      op_kind       <= REQ_TICK;
      time_left     <= '0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      received_byte <= 8'd0;
      absent_flag   <= 1'b0;
      drive_reg     <= 1'b0;
    end else if (step_en) begin
      phase         <= phase_next;
      op_kind       <= op_kind_next;
      time_left     <= time_left_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      received_byte <= received_byte_next;
      absent_flag   <= absent_flag_next;
      drive_reg     <= drive_reg_next;
    end
  end

endmodule

// ===== rtl/core/one_wire_bus_master_core.sv =====
// channel  dir  payload                                             handshake
// req      in   req_type, data_byte, bus_level                     valid/ready
// res      out  drive_low, busy_res, op_done, read_data, no_presence valid/ready
// apb      in   paddr, pwdata, prdata (timing registers at 4*i)    psel/penable
//
// one item per cycle while the result side keeps up: the state registers update on
// the accepting edge and the result lands in the output register on the same edge.
// a new item is taken while the output register is empty or being emptied.
// reset clears the state and output valid and loads the default timings.
// a stalled result holds the output register and stops the request side.
module one_wire_bus_master_core
  import owbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  owbm_req_if.sink              req,
  owbm_res_if.source            res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  res_t res_next;
  res_t res_data;
  logic res_valid;
  logic accept;

  owbm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept while the output register can take a result
  assign req.ready = !res_valid || res.ready;
  assign accept    = req.valid && req.ready;

  owbm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step_en   (accept),
    .req_type  (req.req_type),
    .data_byte (req.data_byte),
    .bus_level (req.bus_level),
    .cfg       (cfg),
    .res_next  (res_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_data <= res_next;
    end
  end

  assign res.valid       = res_valid;
  assign res.drive_low   = res_data.drive_low;
  assign res.busy_res    = res_data.busy_res;
  assign res.op_done     = res_data.op_done;
  assign res.read_data   = res_data.read_data;
  assign res.no_presence = res_data.no_presence;

endmodule

// ===== tb/sv/owbm_status_checker.sv =====
`timescale 1ns / 1ps

module owbm_status_checker
  import owbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  owbm_req_if                   req,
  owbm_res_if                   res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    in_flight
);

  localparam int REPORT_MAX = 10;

  typedef enum logic [3:0] {
    LS_IDLE,
    LS_RST_LOW,
    LS_RST_WAIT,
    LS_RST_REC,
    LS_RD_LOW,
    LS_RD_WAIT,
    LS_RD_TAIL,
    LS_WR_FIRST,
    LS_WR_SECOND,
    LS_WR_GAP
  } line_phase_t;

  // shadow of the timing registers and the sequencer state
  logic [CFG_W-1:0]      timing [NUM_CFG];
  line_phase_t           ph;
  logic [TIMER_BITS-1:0] us_left;
  logic [2:0]            slot;
  logic [7:0]            shreg;
  logic [7:0]            rx_byte;
  logic                  absent;
  logic                  pull_low;

  res_t expected_status [$];
  int   reported;

  // zero counts as one microsecond, long values clip at the timer limit
  function automatic logic [TIMER_BITS-1:0] slot_duration(input logic [CFG_W-1:0] us);
    if (us == '0) begin
      return TIMER_BITS'(1);
    end
    if (int'(us) > TIMER_MAX) begin
      return TIMER_BITS'(TIMER_MAX);
    end
    return TIMER_BITS'(us);
  endfunction

  task automatic enter_phase(input line_phase_t p, input logic [CFG_W-1:0] us,
                             input logic drv);
    ph       = p;
    us_left  = slot_duration(us);
    pull_low = drv;
  endtask

  // low time depends on the bit: short for a one, long for a zero
  task automatic open_write_slot();
    if (shreg[slot]) begin
      enter_phase(LS_WR_FIRST, timing[CFG_WRITE_SHORT], 1'b1);
    end else begin
      enter_phase(LS_WR_FIRST, timing[CFG_WRITE_LONG], 1'b1);
    end
  endtask

  task automatic close_operation(output logic done);
    ph       = LS_IDLE;
    us_left  = '0;
    pull_low = 1'b0;
    done     = 1'b1;
  endtask

  // one item through the sequencer, returns the status it should report
  task automatic advance_bus_timing(input req_t kind, input logic [7:0] data,
                                    input logic lvl, output res_t st);
    logic done;
    done = 1'b0;
    if (ph == LS_IDLE) begin
      case (kind)
        REQ_RESET: begin
          enter_phase(LS_RST_LOW, timing[CFG_RESET_LOW], 1'b1);
        end
        REQ_WRITE: begin
          shreg = data;
          slot  = '0;
          open_write_slot();
        end
        REQ_READ: begin
          shreg = '0;
          slot  = '0;
          enter_phase(LS_RD_LOW, timing[CFG_READ_LOW], 1'b1);
        end
        default: begin
        end
      endcase
    end else if (kind == REQ_TICK) begin
      if (us_left > TIMER_BITS'(1)) begin
        us_left = us_left - TIMER_BITS'(1);
      end else begin
        case (ph)
          LS_RST_LOW: begin
            enter_phase(LS_RST_WAIT, timing[CFG_PRES_WAIT], 1'b0);
          end
          LS_RST_WAIT: begin
            absent = lvl;
            enter_phase(LS_RST_REC, timing[CFG_RESET_REC], 1'b0);
          end
          LS_RST_REC: begin
            close_operation(done);
          end
          LS_RD_LOW: begin
            enter_phase(LS_RD_WAIT, timing[CFG_READ_SAMPLE], 1'b0);
          end
          LS_RD_WAIT: begin
            shreg[slot] = shreg[slot] | lvl;
            enter_phase(LS_RD_TAIL, timing[CFG_READ_TAIL], 1'b0);
          end
          LS_RD_TAIL: begin
            if (slot == 3'd7) begin
              rx_byte = shreg;
              close_operation(done);
            end else begin
              slot = slot + 3'd1;
              enter_phase(LS_RD_LOW, timing[CFG_READ_LOW], 1'b1);
            end
          end
          LS_WR_FIRST: begin
            if (shreg[slot]) begin
              enter_phase(LS_WR_SECOND, timing[CFG_WRITE_LONG], 1'b0);
            end else begin
              enter_phase(LS_WR_SECOND, timing[CFG_WRITE_SHORT], 1'b0);
            end
          end
          LS_WR_SECOND: begin
            enter_phase(LS_WR_GAP, CFG_W'(GAP_US), 1'b0);
          end
          LS_WR_GAP: begin
            if (slot == 3'd7) begin
              close_operation(done);
            end else begin
              slot = slot + 3'd1;
              open_write_slot();
            end
          end
          default: begin
            ph       = LS_IDLE;
            us_left  = '0;
            pull_low = 1'b0;
          end
        endcase
      end
    end
    st.drive_low   = pull_low;
    st.busy_res    = (ph != LS_IDLE);
    st.op_done     = done;
    st.read_data   = rx_byte;
    st.no_presence = absent;
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      timing[CFG_RESET_LOW]   = RST_RESET_LOW;
      timing[CFG_PRES_WAIT]   = RST_PRES_WAIT;
      timing[CFG_RESET_REC]   = RST_RESET_REC;
      timing[CFG_READ_LOW]    = RST_READ_LOW;
      timing[CFG_READ_SAMPLE] = RST_READ_SAMPLE;
      timing[CFG_READ_TAIL]   = RST_READ_TAIL;
      timing[CFG_WRITE_SHORT] = RST_WRITE_SHORT;
      timing[CFG_WRITE_LONG]  = RST_WRITE_LONG;
      ph       = LS_IDLE;
      us_left  = '0;
      slot     = '0;
      shreg    = '0;
      rx_byte  = '0;
      absent   = 1'b0;
      pull_low = 1'b0;
      expected_status.delete();
      mismatches = 0;
      reported   = 0;
    end else begin
      // register write completes in the access phase
      if (psel && penable && pwrite && pready) begin
        timing[paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]] = pwdata[CFG_W-1:0];
      end

      // outgoing status item against the oldest prediction
      if (res.valid && res.ready) begin
        got.drive_low   = res.drive_low;
        got.busy_res    = res.busy_res;
        got.op_done     = res.op_done;
        got.read_data   = res.read_data;
        got.no_presence = res.no_presence;
        if (expected_status.size() == 0) begin
          mismatches = mismatches + 1;
          if (reported < REPORT_MAX) begin
            reported = reported + 1;
            $display("mismatch: unexpected item drive_low=%0b busy=%0b done=%0b data=%02h np=%0b",
                     got.drive_low, got.busy_res, got.op_done, got.read_data,
                     got.no_presence);
          end
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (reported < REPORT_MAX) begin
              reported = reported + 1;
              $display("mismatch: expected drive_low=%0b busy=%0b done=%0b data=%02h np=%0b",
                       want.drive_low, want.busy_res, want.op_done, want.read_data,
                       want.no_presence);
              $display("          actual   drive_low=%0b busy=%0b done=%0b data=%02h np=%0b",
                       got.drive_low, got.busy_res, got.op_done, got.read_data,
                       got.no_presence);
            end
          end
        end
      end

      // incoming item updates the shadow sequencer
      if (req.valid && req.ready) begin
        advance_bus_timing(req_t'(req.req_type), req.data_byte, req.bus_level, want);
        expected_status.push_back(want);
      end
    end
    in_flight = expected_status.size();
  end

endmodule

// ===== tb/sv/tb_one_wire_bus_master_core.sv =====
`timescale 1ns / 1ps

module tb_one_wire_bus_master_core;
  import owbm_pkg::*;

  localparam int CYCLE_LIMIT         = 1000000;
  localparam int RANDOM_ITEMS        = 150;
  localparam int PHASE_ITEMS         = 40;
  localparam int HOLDOFF_CYCLES      = 400;
  localparam int DRAIN_CYCLES        = 10;
  localparam int DEFAULT_WRITE_TICKS = 74;
  localparam int DEFAULT_READ_TICKS  = 61;

  typedef enum int {
    LEVEL_RANDOM,
    LEVEL_LOW,
    LEVEL_HIGH
  } level_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  owbm_req_if req_ch();
  owbm_res_if res_ch();

  int   fails;
  int   pending;
  int   cycles      = 0;
  int   item_count  = 0;
  int   done_count  = 0;
  logic last_busy   = 1'b0;
  logic req_burst   = 1'b1;
  logic res_burst   = 1'b1;
  logic pressure_go = 1'b0;
  logic holdoff;

  logic [CFG_W-1:0] timing_plan [NUM_CFG];

  one_wire_bus_master_core uut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  owbm_status_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (fails),
    .in_flight  (pending)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run time guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // single long receiver stall once random traffic starts
  initial begin
    holdoff <= 1'b0;
    wait (pressure_go);
    @(posedge clk);
    holdoff <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holdoff <= 1'b0;
  end

  // status receiver with random stalls
  initial begin
    int gap;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = res_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0 || holdoff) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        while (holdoff) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      if (res_ch.op_done) begin
        done_count <= done_count + 1;
      end
      last_busy <= res_ch.busy_res;
    end
  end

  function automatic logic pick_level(input level_mode_t lm);
    case (lm)
      LEVEL_LOW:  return 1'b0;
      LEVEL_HIGH: return 1'b1;
      default:    return 1'($urandom);
    endcase
  endfunction

  // offer one item, after a random gap unless in burst mode, return on the accepting edge
  task automatic send_item(input req_t kind, input logic [7:0] data, input logic lvl);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.data_byte <= data;
    req_ch.bus_level <= lvl;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    item_count = item_count + 1;
  endtask

  // a fixed number of ticks with random levels
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(REQ_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // command, then ticks until a done comes back; busy commands mixed in as noise
  task automatic run_op(input req_t cmd, input logic [7:0] data, input level_mode_t lm,
                        input int noise_pct);
    int start_done;
    start_done = done_count;
    send_item(cmd, data, pick_level(lm));
    while (done_count == start_done) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_item(req_t'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
      end else begin
        send_item(REQ_TICK, 8'($urandom), pick_level(lm));
      end
    end
  endtask

  // stop offering and wait until every result item is out
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // drain all status items and make sure the sequencer is back to idle
  task automatic settle();
    forever begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      @(posedge clk);
      if (!last_busy) break;
      run_op(REQ_TICK, 8'($urandom), LEVEL_RANDOM, 0);
    end
  endtask

  task automatic apb_write(input int idx, input logic [APB_DATA_W-1:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx) << (CFG_ADDR_W - CFG_IDX_W);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the whole plan, junk in the unused upper bits
  task automatic load_timings();
    logic [APB_DATA_W-1:0] word;
    for (int i = 0; i < NUM_CFG; i++) begin
      word            = APB_DATA_W'($urandom);
      word[CFG_W-1:0] = timing_plan[i];
      apb_write(i, word);
    end
  endtask

  task automatic plan_all(input logic [CFG_W-1:0] us);
    for (int i = 0; i < NUM_CFG; i++) begin
      timing_plan[i] = us;
    end
  endtask

  // plan holding the power-up timings
  task automatic plan_defaults();
    timing_plan[CFG_RESET_LOW]   = RST_RESET_LOW;
    timing_plan[CFG_PRES_WAIT]   = RST_PRES_WAIT;
    timing_plan[CFG_RESET_REC]   = RST_RESET_REC;
    timing_plan[CFG_READ_LOW]    = RST_READ_LOW;
    timing_plan[CFG_READ_SAMPLE] = RST_READ_SAMPLE;
    timing_plan[CFG_READ_TAIL]   = RST_READ_TAIL;
    timing_plan[CFG_WRITE_SHORT] = RST_WRITE_SHORT;
    timing_plan[CFG_WRITE_LONG]  = RST_WRITE_LONG;
  endtask

  // main stimulus
  initial begin
    int rand_items;
    int phase_start;
    int pick;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.data_byte <= '0;
    req_ch.bus_level <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // write timings straight out of reset: first slot and the start of the next
    req_burst = 1'b1;
    res_burst = 1'b1;
    send_item(REQ_WRITE, 8'h87, 1'b1);
    send_ticks(DEFAULT_WRITE_TICKS);
    drain();
    plan_all('0);
    load_timings();
    settle();

    // default read timings: one full slot, rest of the byte on short timings
    plan_defaults();
    load_timings();
    send_item(REQ_READ, 8'h00, 1'b1);
    send_ticks(DEFAULT_READ_TICKS);
    drain();
    plan_all('0);
    load_timings();
    settle();

    // zero durations act as one microsecond
    req_burst = 1'b0;
    res_burst = 1'b0;
    send_item(REQ_TICK, 8'hFF, 1'b1);
    send_item(REQ_TICK, 8'h00, 1'b0);
    run_op(REQ_RESET, 8'h00, LEVEL_HIGH, 0);
    run_op(REQ_RESET, 8'hFF, LEVEL_LOW, 0);
    run_op(REQ_READ, 8'h00, LEVEL_HIGH, 0);
    run_op(REQ_READ, 8'($urandom), LEVEL_RANDOM, 30);
    settle();

    // random phases of short timings and random traffic
    pressure_go = 1'b1;
    rand_items  = 0;
    while (rand_items < RANDOM_ITEMS) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          timing_plan[i] = '0;
        end else if (pick < 8) begin
          timing_plan[i] = CFG_W'($urandom_range(1, 3));
        end else begin
          timing_plan[i] = CFG_W'($urandom_range(1, 8));
        end
      end
      req_burst = ($urandom_range(0, 3) == 0);
      res_burst = ($urandom_range(0, 3) == 0);
      load_timings();
      phase_start = item_count;
      while (item_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          req_burst = ~req_burst;
        end
        if ($urandom_range(0, 7) == 0) begin
          send_item(REQ_TICK, 8'($urandom), 1'($urandom));
        end else begin
          run_op(req_t'($urandom_range(1, 3)), 8'($urandom), LEVEL_RANDOM, 6);
        end
      end
      rand_items = rand_items + (item_count - phase_start);
      settle();
    end

    // wind down and give the verdict
    req_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/owbm_pkg.sv
rtl/core/owbm_if.sv
rtl/core/owbm_cfg_regs.sv
rtl/core/owbm_seq.sv
rtl/core/one_wire_bus_master_core.sv
tb/sv/owbm_status_checker.sv
tb/sv/tb_one_wire_bus_master_core.sv
